// ===== src/fixed_point_scaled_dif_fft_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled DIF FFT
// Shared immediate-style wrappers around concurrent properties on clk / rst.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_SCALED_DIF_FFT_MACROS_SVH
`define FIXED_POINT_SCALED_DIF_FFT_MACROS_SVH

// same-cycle implication
`define FSDFFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FSDFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fsdfft_pkg.sv =====
// ----------------------------------------------------------------------------
// fsdfft_pkg
// Field widths, payload types and request kind codes for the scaled DIF FFT.
// ----------------------------------------------------------------------------
package fsdfft_pkg;

  localparam int DATA_W  = 16;
  localparam int INDEX_W = 10;
  localparam int KIND_W  = 2;
  localparam int LOG_W   = 4;

  typedef logic [KIND_W-1:0]         kind_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [DATA_W-1:0]  data_t;

  localparam kind_t KIND_TW_WR   = 2'd0;
  localparam kind_t KIND_SMP_WR  = 2'd1;
  localparam kind_t KIND_RUN     = 2'd2;
  localparam kind_t KIND_BIN_RD  = 2'd3;

  localparam logic [LOG_W-1:0] LOG_SIZE_RST = 4'd10;

endpackage

// ===== src/fsdfft_if.sv =====
// ----------------------------------------------------------------------------
// fsdfft request / result channels
// Valid/ready channels carrying command requests and bin results.
// ----------------------------------------------------------------------------
interface fsdfft_cmd_if import fsdfft_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_t  kind;
  index_t index;
  data_t  in_re;
  data_t  in_im;

  modport source (output valid, kind, index, in_re, in_im, input ready);
  modport sink   (input valid, kind, index, in_re, in_im, output ready);
endinterface

interface fsdfft_rsp_if import fsdfft_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t out_re;
  data_t out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink   (input valid, out_re, out_im, output ready);
endinterface

// ===== src/fixed_point_scaled_dif_fft.sv =====
// ----------------------------------------------------------------------------
// fixed_point_scaled_dif_fft
// In-place radix-2 DIF FFT on Q15 complex samples, one shared multiplier,
// final two stages fused into a radix-4 pass, output in bit-reversed order.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                         notes
//  cmd       in   kind, index, in_re, in_im       load twiddle/sample, run, read
//  rsp       out  out_re, out_im                  one result per read-bin request
//  cfg       in   cfg_we, cfg_wdata (log_size)    write only, idle time only
//
// Schedule: twiddle/sample writes go into their store as they are accepted. A
// read passes through the memory read, then the output register. A run works
// through the radix-2 stages pair by pair (4 reads, sum/diff, 8 passes through
// the single 16x16 multiplier, 4 writes per butterfly pair), then the radix-4
// pass; the sample memory's one read port and the one multiplier set this.
// Reset: synchronous, active high; clears control only, stores hold garbage.
// Stalls: cmd is not ready while a run or read is in flight, or while a
// result sits unaccepted in the output register.
// ----------------------------------------------------------------------------
`include "fixed_point_scaled_dif_fft_macros.svh"

module fixed_point_scaled_dif_fft
  import fsdfft_pkg::*;
#(
  parameter int LOG_MAX_POINTS = 10
) (
  input  logic             clk,
  input  logic             rst,
  fsdfft_cmd_if.sink       cmd,
  fsdfft_rsp_if.source     rsp,
  input  logic             cfg_we,
  input  logic [LOG_W-1:0] cfg_wdata
);

  localparam int AW    = LOG_MAX_POINTS;
  localparam int DEPTH = 1 << AW;
  localparam int TW_SH = LOG_MAX_POINTS - 2;
  localparam int TW_AW = (TW_SH > 0) ? TW_SH : 1;
  localparam int TW_D  = 1 << TW_AW;
  localparam int LG_W  = $clog2(LOG_MAX_POINTS + 1) + 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RDW  = 2'd1;
  localparam logic [1:0] ST_R2   = 2'd2;
  localparam logic [1:0] ST_R4   = 2'd3;

  // radix-2 pair schedule points
  localparam logic [4:0] C_SUM    = 5'd5;
  localparam logic [4:0] C_MUL0   = 5'd6;
  localparam logic [4:0] C_MUL7   = 5'd13;
  localparam logic [4:0] C_ACC0   = 5'd7;
  localparam logic [4:0] C_ACC7   = 5'd14;
  localparam logic [4:0] C_WR0    = 5'd15;
  localparam logic [4:0] C_WR3    = 5'd18;
  // radix-4 schedule points
  localparam logic [4:0] C4_WR0   = 5'd6;
  localparam logic [4:0] C4_WR3   = 5'd9;

  logic [1:0]       state;
  logic [4:0]       cnt;
  logic [LOG_W-1:0] log_size;
  logic             out_valid;
  logic             out_zero;
  data_t            out_re_q, out_im_q;

  // memories
  logic [31:0] smp_mem [DEPTH];
  logic [31:0] tw_mem  [TW_D];
  logic [31:0] rd_data;
  logic [31:0] tw_q;

  // loop registers
  logic [AW-1:0]    pa;
  logic [AW-1:0]    half;
  logic [AW-1:0]    jcnt;
  logic [TW_AW-1:0] iw;
  logic [TW_AW-1:0] step;

  // butterfly operands and results
  data_t xr [4];
  data_t xi [4];
  data_t res [4];
  logic signed [31:0] prod;
  logic signed [32:0] acc;

  // clamped size
  logic [LG_W-1:0] lg;
  logic [AW:0]     n_pts;
  always_comb begin
    if (log_size < LOG_W'(2)) begin
      lg = LG_W'(2);
    end else if (LG_W'(log_size) > LG_W'(LOG_MAX_POINTS)) begin
      lg = LG_W'(LOG_MAX_POINTS);
    end else begin
      lg = LG_W'(log_size);
    end
    n_pts = (AW+1)'(1) << lg;
  end

  // request decode
  logic [31:0] idx_ext;
  logic        smp_ok, tw_ok, cmd_acc;
  assign idx_ext = 32'(cmd.index);
  assign smp_ok  = (idx_ext >> LOG_MAX_POINTS) == 32'd0;
  assign tw_ok   = (idx_ext >> TW_SH) == 32'd0;
  assign cmd.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign cmd_acc   = cmd.valid && cmd.ready;

  assign rsp.valid  = out_valid;
  assign rsp.out_re = out_re_q;
  assign rsp.out_im = out_im_q;

  // quarter offsets within a radix-2 pair
  function automatic logic [AW-1:0] quad_off(input logic [1:0] sel, input logic [AW-1:0] h);
    logic [AW-1:0] r;
    case (sel)
      2'd0:    r = '0;
      2'd1:    r = h;
      2'd2:    r = h << 1;
      default: r = (h << 1) + h;
    endcase
    return r;
  endfunction

  function automatic data_t halve(input logic [15:0] v);
    return data_t'({v[15], v[15:1]});
  endfunction

  logic [1:0] wr_sel2, wr_sel4, cap_sel;
  logic [4:0] t2, t4, tc;
  assign tc      = cnt - 5'd1;
  assign t2      = cnt - C_WR0;
  assign t4      = cnt - C4_WR0;
  assign cap_sel = tc[1:0];
  assign wr_sel2 = t2[1:0];
  assign wr_sel4 = t4[1:0];

  // sample memory port control
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;
  logic [31:0]   wr_data;
  data_t         w4_re, w4_im;

  always_comb begin
    rd_addr = idx_ext[AW-1:0];
    wr_addr = idx_ext[AW-1:0];
    wr_data = {cmd.in_im, cmd.in_re};
    mem_we  = 1'b0;
    w4_re   = '0;
    w4_im   = '0;
    unique case (state)
      ST_IDLE: begin
        mem_we = cmd_acc && (cmd.kind == KIND_SMP_WR) && smp_ok;
      end
      ST_R2: begin
        rd_addr = pa + quad_off(cnt[1:0], half);
        wr_addr = pa + quad_off(wr_sel2, half);
        mem_we  = (cnt >= C_WR0) && (cnt <= C_WR3);
        case (wr_sel2)
          2'd0:    wr_data = {xi[0], xr[0]};
          2'd1:    wr_data = {xi[1], xr[1]};
          2'd2:    wr_data = {res[1], res[0]};
          default: wr_data = {res[3], res[2]};
        endcase
      end
      ST_R4: begin
        rd_addr = pa + AW'(cnt[1:0]);
        wr_addr = pa + AW'(wr_sel4);
        mem_we  = (cnt >= C4_WR0) && (cnt <= C4_WR3);
        case (wr_sel4)
          2'd0: begin
            w4_re = xr[0] + xr[1];
            w4_im = xi[0] + xi[1];
          end
          2'd1: begin
            w4_re = xr[0] - xr[1];
            w4_im = xi[0] - xi[1];
          end
          2'd2: begin
            w4_re = xr[2] + xr[3];
            w4_im = xi[2] + xi[3];
          end
          default: begin
            w4_re = xr[2] - xr[3];
            w4_im = xi[2] - xi[3];
          end
        endcase
        wr_data = {w4_im, w4_re};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      smp_mem[wr_addr] <= wr_data;
    end
    rd_data <= smp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.kind == KIND_TW_WR) && tw_ok) begin
      tw_mem[idx_ext[TW_AW-1:0]] <= {cmd.in_im, cmd.in_re};
    end
    tw_q <= tw_mem[iw];
  end

  // shared multiplier: product k = cnt - C_MUL0, registered, then accumulated in the next cycle
  data_t      wr_c, wi_c, ma, mb;
  logic [4:0] tk, ta;
  logic [2:0] kmul, kacc;
  logic signed [32:0] p_ext, acc_sum;
  assign wr_c = data_t'(tw_q[15:0]);
  assign wi_c = data_t'(tw_q[31:16]);
  assign tk   = cnt - C_MUL0;
  assign ta   = cnt - C_ACC0;
  assign kmul = tk[2:0];
  assign kacc = ta[2:0];

  always_comb begin
    case (kmul)
      3'd0:    begin ma = xr[2]; mb = wr_c; end
      3'd1:    begin ma = xi[2]; mb = wi_c; end
      3'd2:    begin ma = xr[2]; mb = wi_c; end
      3'd3:    begin ma = xi[2]; mb = wr_c; end
      3'd4:    begin ma = xr[3]; mb = wi_c; end
      3'd5:    begin ma = xi[3]; mb = wr_c; end
      3'd6:    begin ma = xi[3]; mb = wi_c; end
      default: begin ma = xr[3]; mb = wr_c; end
    endcase
    p_ext = 33'(prod);
    // first and last pair terms are subtracted
    if (kacc == 3'd1 || kacc == 3'd7) begin
      acc_sum = acc - p_ext;
    end else begin
      acc_sum = acc + p_ext;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (state == ST_R2 && cnt >= C_ACC0 && cnt <= C_ACC7) begin
      if (!kacc[0]) begin
        acc <= p_ext;
      end else begin
        res[kacc[2:1]] <= acc_sum[30:15];
      end
    end
  end

  // operand registers
  logic [AW:0] pa_blk_next, pa_r4_next;
  assign pa_blk_next = (AW+1)'(pa) + (AW+1)'(1) + (AW+1)'(quad_off(2'd3, half));
  assign pa_r4_next  = (AW+1)'(pa) + (AW+1)'(4);

  always_ff @(posedge clk) begin
    if ((state == ST_R2 || state == ST_R4) && cnt >= 5'd1 && cnt <= 5'd4) begin
      xr[cap_sel] <= halve(rd_data[15:0]);
      xi[cap_sel] <= halve(rd_data[31:16]);
    end
    if (state == ST_R2 && cnt == C_SUM) begin
      xr[0] <= xr[0] + xr[2];
      xi[0] <= xi[0] + xi[2];
      xr[1] <= xr[1] + xr[3];
      xi[1] <= xi[1] + xi[3];
      xr[2] <= xr[0] - xr[2];
      xi[2] <= xi[0] - xi[2];
      xr[3] <= xr[1] - xr[3];
      xi[3] <= xi[1] - xi[3];
    end
    if (state == ST_R4 && cnt == C_SUM) begin
      xr[0] <= xr[0] + xr[2];
      xi[0] <= xi[0] + xi[2];
      xr[1] <= xr[1] + xr[3];
      xi[1] <= xi[1] + xi[3];
      xr[2] <= xr[0] - xr[2];
      xi[2] <= xi[0] - xi[2];
      // (x1 - x3) times -j
      xr[3] <= xi[1] - xi[3];
      xi[3] <= xr[3] - xr[1];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      log_size  <= LOG_SIZE_RST;
    end else begin
      if (cfg_we) begin
        log_size <= cfg_wdata;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (cmd_acc && cmd.kind == KIND_BIN_RD) begin
            state    <= ST_RDW;
            out_zero <= !smp_ok;
          end else if (cmd_acc && cmd.kind == KIND_RUN) begin
            pa   <= '0;
            jcnt <= '0;
            iw   <= '0;
            step <= TW_AW'(1);
            half <= AW'(1) << (lg - LG_W'(2));
            state <= (lg == LG_W'(2)) ? ST_R4 : ST_R2;
          end
        end
        ST_RDW: begin
          out_valid <= 1'b1;
          out_re_q  <= out_zero ? data_t'(0) : data_t'(rd_data[15:0]);
          out_im_q  <= out_zero ? data_t'(0) : data_t'(rd_data[31:16]);
          state     <= ST_IDLE;
        end
        ST_R2: begin
          if (cnt == C_WR3) begin
            cnt <= '0;
            if (jcnt == half - AW'(1)) begin
              jcnt <= '0;
              iw   <= '0;
              if (pa_blk_next == n_pts) begin
                pa <= '0;
                if (half == AW'(2)) begin
                  state <= ST_R4;
                end else begin
                  half <= half >> 1;
                  step <= step << 1;
                end
              end else begin
                pa <= pa_blk_next[AW-1:0];
              end
            end else begin
              jcnt <= jcnt + AW'(1);
              pa   <= pa + AW'(1);
              iw   <= iw + step;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_R4: begin
          if (cnt == C4_WR3) begin
            cnt <= '0;
            if (pa_r4_next == n_pts) begin
              state <= ST_IDLE;
            end else begin
              pa <= pa_r4_next[AW-1:0];
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `FSDFFT_ASSERT_NOW(a_busy_not_ready, state != ST_IDLE, !cmd.ready, "cmd ready while busy")
  `FSDFFT_ASSERT_NEXT(a_read_goes_wait, cmd_acc && cmd.kind == KIND_BIN_RD, state == ST_RDW, "read did not start")
  `FSDFFT_ASSERT_NEXT(a_wait_gives_result, state == ST_RDW, out_valid && state == ST_IDLE, "read result missing")
  `FSDFFT_ASSERT_NEXT(a_run_starts, cmd_acc && cmd.kind == KIND_RUN, state == ST_R2 || state == ST_R4, "run did not start")
  `FSDFFT_ASSERT_NOW(a_cnt_range, state == ST_R2 || state == ST_R4, cnt <= C_WR3, "schedule counter overrun")

endmodule

// ===== dv/tb_fixed_point_scaled_dif_fft.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_scaled_dif_fft
// Self-checking bench for the scaled DIF FFT. It loads both stores, runs
// transforms at many sizes and reads back bins. A behavioral model of the
// butterflies predicts every read, and each result is compared to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_point_scaled_dif_fft
  import fsdfft_pkg::*;
();

  localparam int NPTS     = 1024;
  localparam int TW_N     = NPTS / 4;
  localparam int WD_LIMIT = 300000;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
  } bin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LOG_W-1:0] cfg_wdata = '0;

  fsdfft_cmd_if cmd_ch ();
  fsdfft_rsp_if rsp_ch ();

  fixed_point_scaled_dif_fft u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // bench-side copies of the block state
  logic [31:0] smp_mem [NPTS];   // {im, re}
  logic [31:0] tw_mem  [TW_N];   // {im, re}
  int          cur_log = LOG_SIZE_RST;
  bin_t        pending_bins [$];
  int          errors = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          quiet_cnt = 0;

  // ---------------- butterfly arithmetic ----------------
  function automatic logic [15:0] halve16(logic [15:0] v);
    return {v[15], v[15:1]};
  endfunction

  function automatic longint smul(logic [15:0] a, logic [15:0] b);
    return longint'($signed(a)) * longint'($signed(b));
  endfunction

  function automatic logic [15:0] q15_keep(longint s);
    longint t;
    t = s >>> 15;
    return t[15:0];
  endfunction

  function automatic int clamp_log(int v);
    if (v < 2) return 2;
    if (v > 10) return 10;
    return v;
  endfunction

  // how long to wait for a run at the current size, with a margin
  function automatic int run_cycles();
    int l, n;
    l = clamp_log(cur_log);
    n = 1 << l;
    return (n / 4) * (l - 2) * 19 + (n / 4) * 10 + 64;
  endfunction

  task automatic transform_store();
    int lg, n, stride, step, half, st, blk, j, iw;
    int pa, pb, qa, qb;
    logic [15:0] par, pai, pbr, pbi, qar, qai, qbr, qbi, wr, wi;
    logic [15:0] dar, dai, dbr, dbi, sar, sai, sbr, sbi, rr, ri;
    logic [15:0] x0r, x0i, x1r, x1i, x2r, x2i, x3r, x3i;
    lg = clamp_log(cur_log);
    n = 1 << lg;
    stride = n >> 1;
    step = 1;
    // radix-2 stages, each input halved first
    for (st = 0; st + 2 < lg; st++) begin
      half = stride >> 1;
      for (blk = 0; blk < n; blk += stride * 2) begin
        iw = 0;
        for (j = 0; j < half; j++) begin
          pa = blk + j;
          pb = blk + half + j;
          qa = blk + stride + j;
          qb = qa + half;
          par = halve16(smp_mem[pa][15:0]); pai = halve16(smp_mem[pa][31:16]);
          pbr = halve16(smp_mem[pb][15:0]); pbi = halve16(smp_mem[pb][31:16]);
          qar = halve16(smp_mem[qa][15:0]); qai = halve16(smp_mem[qa][31:16]);
          qbr = halve16(smp_mem[qb][15:0]); qbi = halve16(smp_mem[qb][31:16]);
          wr = tw_mem[iw % TW_N][15:0];
          wi = tw_mem[iw % TW_N][31:16];
          dar = par - qar; dai = pai - qai;
          dbr = pbr - qbr; dbi = pbi - qbi;
          smp_mem[pa] = {16'(pai + qai), 16'(par + qar)};
          smp_mem[pb] = {16'(pbi + qbi), 16'(pbr + qbr)};
          smp_mem[qa] = {q15_keep(smul(dar, wi) + smul(dai, wr)),
                         q15_keep(smul(dar, wr) - smul(dai, wi))};
          // second butterfly of the pair: twiddle times -j
          smp_mem[qb] = {q15_keep(smul(dbi, wi) - smul(dbr, wr)),
                         q15_keep(smul(dbr, wi) + smul(dbi, wr))};
          iw += step;
        end
      end
      stride >>= 1;
      step <<= 1;
    end
    // fused radix-4 tail, single halving
    for (j = 0; j < n; j += 4) begin
      x0r = halve16(smp_mem[j][15:0]);   x0i = halve16(smp_mem[j][31:16]);
      x1r = halve16(smp_mem[j+1][15:0]); x1i = halve16(smp_mem[j+1][31:16]);
      x2r = halve16(smp_mem[j+2][15:0]); x2i = halve16(smp_mem[j+2][31:16]);
      x3r = halve16(smp_mem[j+3][15:0]); x3i = halve16(smp_mem[j+3][31:16]);
      sar = x0r + x2r; sai = x0i + x2i;
      sbr = x1r + x3r; sbi = x1i + x3i;
      dar = x0r - x2r; dai = x0i - x2i;
      rr  = x1i - x3i; ri  = x3r - x1r;
      smp_mem[j]   = {16'(sai + sbi), 16'(sar + sbr)};
      smp_mem[j+1] = {16'(sai - sbi), 16'(sar - sbr)};
      smp_mem[j+2] = {16'(dai + ri),  16'(dar + rr)};
      smp_mem[j+3] = {16'(dai - ri),  16'(dar - rr)};
    end
  endtask

  // update the bench copy for one accepted request
  task automatic apply_request(kind_t k, index_t idx, logic [15:0] re, logic [15:0] im);
    bin_t b;
    case (k)
      KIND_TW_WR: begin
        if (idx < TW_N) tw_mem[idx] = {im, re};
      end
      KIND_SMP_WR: begin
        smp_mem[idx] = {im, re};
      end
      KIND_RUN: begin
        transform_store();
      end
      default: begin
        b.re = smp_mem[idx][15:0];
        b.im = smp_mem[idx][31:16];
        pending_bins.push_back(b);
      end
    endcase
  endtask

  // ---------------- request driver ----------------
  // Entered and left right after a rising edge.
  task automatic send_req(kind_t k, index_t idx, logic [15:0] re, logic [15:0] im);
    while ($urandom_range(99) < snd_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind  <= k;
    cmd_ch.index <= idx;
    cmd_ch.in_re <= re;
    cmd_ch.in_im <= im;
    forever begin
      @(negedge clk);
      if (cmd_ch.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    apply_request(k, idx, re, im);
  endtask

  // wait for every pending bin, then let a run finish
  task automatic drain();
    int extra;
    cmd_ch.valid <= 1'b0;
    while (pending_bins.size() > 0) @(posedge clk);
    extra = run_cycles();
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_log_size(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LOG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_log = v;
  endtask

  function automatic logic [15:0] rand_data();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'hffff;
    if (r == 3) return 16'h0000;
    return 16'($urandom());
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(negedge clk) begin
    bin_t exp_bin;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, rsp_ch.out_re, rsp_ch.out_im);
        errors++;
      end else begin
        exp_bin = pending_bins.pop_front();
        if (rsp_ch.out_re !== exp_bin.re) begin
          $display("%0t: out_re expected %h actual %h", $time, exp_bin.re, rsp_ch.out_re);
          errors++;
        end
        if (rsp_ch.out_im !== exp_bin.im) begin
          $display("%0t: out_im expected %h actual %h", $time, exp_bin.im, rsp_ch.out_im);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no request moving on either channel
  always @(negedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // fill both stores, then run at the reset size and read a spread of bins
  task automatic test_load_and_reset_size();
    int i;
    for (i = 0; i < TW_N; i++) send_req(KIND_TW_WR, index_t'(i), rand_data(), rand_data());
    for (i = 0; i < NPTS; i++) send_req(KIND_SMP_WR, index_t'(i), rand_data(), rand_data());
    send_req(KIND_RUN, '0, '0, '0);
    for (i = 0; i < 6; i++) send_req(KIND_BIN_RD, index_t'($urandom_range(1023)), '0, '0);
    send_req(KIND_BIN_RD, 10'd0, '0, '0);
    send_req(KIND_BIN_RD, 10'd1023, '0, '0);
  endtask

  // field extremes through write and read back
  task automatic test_extremes();
    send_req(KIND_SMP_WR, 10'd0, 16'h7fff, 16'h8000);
    send_req(KIND_SMP_WR, 10'd1023, 16'h8000, 16'h7fff);
    send_req(KIND_SMP_WR, 10'd512, 16'hffff, 16'h0000);
    send_req(KIND_BIN_RD, 10'd0, '0, '0);
    send_req(KIND_BIN_RD, 10'd1023, '0, '0);
    send_req(KIND_BIN_RD, 10'd512, '0, '0);
  endtask

  // sizes below 2 and above the maximum clamp; twiddle writes past the table drop
  task automatic test_size_clamp_and_tw_range();
    int i;
    set_log_size(0);
    send_req(KIND_TW_WR, 10'd256, 16'h7fff, 16'h7fff);
    send_req(KIND_TW_WR, 10'd1023, 16'h8000, 16'h8000);
    send_req(KIND_RUN, '0, '0, '0);
    for (i = 0; i < 4; i++) send_req(KIND_BIN_RD, index_t'(i), '0, '0);
    set_log_size(1);
    send_req(KIND_RUN, '0, '0, '0);
    send_req(KIND_BIN_RD, 10'd3, '0, '0);
    set_log_size(15);
    send_req(KIND_RUN, '0, '0, '0);
    send_req(KIND_BIN_RD, 10'd700, '0, '0);
  endtask

  // random mix at small sizes; idling moves to the sender, then stops
  task automatic test_random();
    int sizes [6] = '{2, 3, 0, 5, 1, 4};
    int p, i, r, runs, lim, n;
    for (p = 0; p < 6; p++) begin
      set_log_size(sizes[p]);
      if (p == 2) begin
        snd_idle = 88;
        rcv_idle = 9;
      end else if (p == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      n = 1 << clamp_log(sizes[p]);
      lim = (n >= 128) ? 2 : 20;
      runs = 0;
      for (i = 0; i < 12; i++) begin
        r = $urandom_range(99);
        if (i == 6) drain();
        if (r < 15) begin
          send_req(KIND_TW_WR, index_t'($urandom_range(1023)), rand_data(), rand_data());
        end else if (r < 45) begin
          send_req(KIND_SMP_WR,
                   index_t'(r[0] ? $urandom_range(1023) : $urandom_range(n - 1)),
                   rand_data(), rand_data());
        end else if (r < 60 && runs < lim) begin
          runs++;
          send_req(KIND_RUN, index_t'($urandom()), rand_data(), rand_data());
        end else begin
          send_req(KIND_BIN_RD,
                   index_t'(r[0] ? $urandom_range(1023) : $urandom_range(n - 1)),
                   rand_data(), rand_data());
        end
      end
    end
  endtask

  initial begin
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind  <= KIND_RUN;
    cmd_ch.index <= '0;
    cmd_ch.in_re <= '0;
    cmd_ch.in_im <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle = 9;
    rcv_idle = 88;
    test_load_and_reset_size();
    test_extremes();
    test_size_clamp_and_tw_range();
    test_random();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/fsdfft_pkg.sv
src/fsdfft_if.sv
src/fixed_point_scaled_dif_fft.sv
dv/tb_fixed_point_scaled_dif_fft.sv
